/* src/sample_clock_divider_search_defines.svh */
// Assertion macros shared by the sample clock divider search RTL.
// Included by scds_div.sv and sample_clock_divider_search.sv; no other dependencies.
`ifndef SAMPLE_CLOCK_DIVIDER_SEARCH_DEFINES_SVH
`define SAMPLE_CLOCK_DIVIDER_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/scds_pkg.sv */
// Package for the sample clock divider search: widths, constants and register indexes.
// Used by scds_div.sv and sample_clock_divider_search.sv; depends on nothing.
package scds_pkg;

  localparam int DATA_W    = 32;
  localparam int PRESC_W   = 3;
  localparam int DIVC_W    = 8;
  localparam int N_W       = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0]  CLOCK_RESET = 32'd25000000;
  localparam logic [DATA_W-1:0]  DIV_MAX     = 32'd256;
  localparam logic [PRESC_W-1:0] PRESC_SLOW  = 3'd7;
  localparam logic [N_W-1:0]     DIV_SLOW    = 9'd255;
  localparam logic [N_W-1:0]     DIV_ONE     = 9'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_HZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_EXT     = 2'd2;

  // Total divide ratio n * 2^p; it never exceeds 256 * 128 and fits 16 bits.
  function automatic logic [15:0] ratio(input logic [N_W-1:0] n, input logic [PRESC_W-1:0] p);
    ratio = {7'd0, n} << p;
  endfunction

endpackage

/* src/sample_clock_divider_search.sv */
// Top level of the sample clock divider search: registers, search sequencer, result word.
// Depends on scds_pkg, scds_div and sample_clock_divider_search_defines.svh.
//
//   Channel   Ports                                        Handshake
//   input     in_requested_hz                              start high while busy low
//   result    out_prescaler_code .. out_zero_request       out_valid strobe, one cycle
//   config    cfg_index, cfg_wdata                         cfg_we, taken at once
//
// The bit-serial divider produces one quotient bit per cycle, and a normal request
// needs two divisions with a scan of the first quotient between them.
// Reset is synchronous and active low; it restores the clock registers to 25 MHz
// and the internal clock selection, and returns the sequencer to idle.
// The receiver cannot stall; busy stays high until the cycle of the result strobe.
`include "sample_clock_divider_search_defines.svh"

module sample_clock_divider_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [scds_pkg::DATA_W-1:0]      in_requested_hz,
  output logic                             out_valid,
  output logic [scds_pkg::PRESC_W-1:0]     out_prescaler_code,
  output logic [scds_pkg::DIVC_W-1:0]      out_divider_code,
  output logic [scds_pkg::DATA_W-1:0]      out_achieved_hz,
  output logic                             out_was_clamped,
  output logic                             out_range_capped,
  output logic                             out_zero_request,
  input  logic                             cfg_we,
  input  logic [scds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scds_pkg::DATA_W-1:0]      cfg_wdata
);
  import scds_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DIV2 = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;

  logic [DATA_W-1:0]  int_hz_r;
  logic [DATA_W-1:0]  ext_hz_r;
  logic               use_ext_r;

  logic [DATA_W-1:0]  board_r;
  logic [DATA_W-1:0]  dvs_r;
  logic               div_start_r;
  logic [DATA_W-1:0]  q_r;
  logic [PRESC_W-1:0] p_r;
  logic [N_W-1:0]     n_r;
  logic               clamped_r;
  logic               capped_r;
  logic               zero_r;

  logic               out_valid_r;
  logic [PRESC_W-1:0] out_p_r;
  logic [DIVC_W-1:0]  out_n_r;
  logic [DATA_W-1:0]  out_hz_r;
  logic               out_clamped_r;
  logic               out_capped_r;
  logic               out_zero_r;

  logic               accept;
  logic [DATA_W-1:0]  board_sel;
  logic               div_done;
  logic [DATA_W-1:0]  div_quo;
  logic               scan_fits;
  logic               scan_cap;
  logic [N_W-1:0]     scan_n;
  logic [PRESC_W-1:0] scan_p;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign board_sel = use_ext_r ? ext_hz_r : int_hz_r;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_hz_r  <= CLOCK_RESET;
      ext_hz_r  <= CLOCK_RESET;
      use_ext_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERNAL_HZ: int_hz_r  <= cfg_wdata;
        CFG_EXTERNAL_HZ: ext_hz_r  <= cfg_wdata;
        CFG_USE_EXT:     use_ext_r <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Shared divider: first board / request, then board / (n * 2^p).
  scds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (board_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Since floor(floor(b / r) / 2^p) equals floor(b / (r * 2^p)), the search
  // shifts the first quotient right one place per cycle until it is at most
  // 256. If the prescaler would pass 7, the slowest setting is taken.
  always_comb begin
    scan_fits = (q_r <= DIV_MAX);
    scan_cap  = !scan_fits && (p_r == PRESC_SLOW);
    scan_n    = scan_fits ? q_r[N_W-1:0] : DIV_SLOW;
    scan_p    = scan_fits ? p_r : PRESC_SLOW;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_requested_hz == '0 || board_sel < in_requested_hz) begin
            state_nxt = ST_DIV2;
          end else begin
            state_nxt = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_fits || scan_cap) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= (state_r == ST_IDLE && accept) ||
                     (state_r == ST_SCAN && (scan_fits || scan_cap));
      out_valid_r <= (state_r == ST_DIV2) && div_done;
    end
  end

  // Working registers of the search. Special cases go straight to the
  // achieved-rate division with their fixed setting.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          board_r   <= board_sel;
          clamped_r <= 1'b0;
          capped_r  <= 1'b0;
          zero_r    <= 1'b0;
          p_r       <= '0;
          if (in_requested_hz == '0) begin
            zero_r <= 1'b1;
            p_r    <= PRESC_SLOW;
            n_r    <= DIV_SLOW;
            dvs_r  <= {16'd0, ratio(DIV_SLOW, PRESC_SLOW)};
          end else if (board_sel < in_requested_hz) begin
            clamped_r <= 1'b1;
            n_r       <= DIV_ONE;
            dvs_r     <= {16'd0, ratio(DIV_ONE, '0)};
          end else begin
            dvs_r <= in_requested_hz;
          end
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          q_r <= div_quo;
        end
      end
      ST_SCAN: begin
        if (scan_fits || scan_cap) begin
          n_r      <= scan_n;
          p_r      <= scan_p;
          capped_r <= scan_cap;
          dvs_r    <= {16'd0, ratio(scan_n, scan_p)};
        end else begin
          q_r <= {1'b0, q_r[DATA_W-1:1]};
          p_r <= p_r + 1'b1;
        end
      end
      ST_DIV2: ;
      default: ;
    endcase
  end

  // Result word, held until the next one is produced.
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV2 && div_done) begin
      out_p_r       <= p_r;
      out_n_r       <= n_r[DIVC_W-1:0];
      out_hz_r      <= div_quo;
      out_clamped_r <= clamped_r;
      out_capped_r  <= capped_r;
      out_zero_r    <= zero_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_prescaler_code = out_p_r;
  assign out_divider_code   = out_n_r;
  assign out_achieved_hz    = out_hz_r;
  assign out_was_clamped    = out_clamped_r;
  assign out_range_capped   = out_capped_r;
  assign out_zero_request   = out_zero_r;

  `SCDS_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE, "result strobe while busy")
  `SCDS_ASSERT_SAME(a_one_flag, clk, rst_n, out_valid_r, $onehot0({out_clamped_r, out_capped_r, out_zero_r}), "conflicting result flags")
  `SCDS_ASSERT_SAME(a_slow_setting, clk, rst_n, out_valid_r && (out_zero_r || out_capped_r), out_p_r == PRESC_SLOW && out_n_r == DIV_SLOW[DIVC_W-1:0], "slowest setting not reported")
  `SCDS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !out_valid_r, "accepted word did not start the search")

endmodule

/* src/scds_div.sv */
// Restoring unsigned divider that produces one quotient bit per clock cycle.
// Depends on scds_pkg and sample_clock_divider_search_defines.svh.
`include "sample_clock_divider_search_defines.svh"

module scds_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [scds_pkg::DATA_W-1:0]  dividend,
  input  logic [scds_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [scds_pkg::DATA_W-1:0]  quotient
);
  import scds_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              active_r;
  logic              done_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  // The dividend shifts out of the top of the quotient register into the
  // partial remainder while quotient bits shift in at the bottom.
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(DATA_W - 1);
      end else if (active_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (active_r) begin
      rem_r <= trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ~trial[DATA_W]};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `SCDS_ASSERT_SAME(a_no_restart, clk, rst_n, start, !active_r, "divider restarted while active")
  `SCDS_ASSERT_NEXT(a_last_step, clk, rst_n, active_r && cnt_r == '0 && !start, done_r && !active_r, "divider missed its final step")
  `SCDS_ASSERT_SAME(a_done_idle, clk, rst_n, done_r, !active_r, "done raised while still dividing")

endmodule
